// ----- hdl/tai_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tai_pkg
// Shared types and constants of the three-axis cascaded high-pass filter.
// ----------------------------------------------------------------------------
package tai_pkg;

  // Axis count is fixed by the x, y, z fields of the channels
  localparam int AXES            = 3;
  localparam int AXIS_BITS       = $clog2(AXES);
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;
  localparam int ACC_BITS        = 64;

  // History words kept per axis in the state memory
  localparam int HIST_WORDS      = 5;

  // Register file and APB port
  localparam int NUM_REGS        = 8;
  localparam int REG_IDX_BITS    = 3;
  localparam int APB_ADDR_BITS   = 5;
  localparam int APB_DATA_BITS   = 32;

  // Coefficient register indexes; also the multiply-accumulate term codes
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_S1_FEED_0 = 3'd0,
    REG_S1_FEED_1 = 3'd1,
    REG_S1_FEED_2 = 3'd2,
    REG_S1_BACK_1 = 3'd3,
    REG_S1_BACK_2 = 3'd4,
    REG_S2_FEED_0 = 3'd5,
    REG_S2_FEED_1 = 3'd6,
    REG_S2_BACK_1 = 3'd7
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC1,
    ST_FIN1,
    ST_RND1,
    ST_MAC2,
    ST_FIN2,
    ST_RND2,
    ST_DONE
  } state_e;

endpackage

// ----- hdl/tai_smp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tai_smp_if
// Input channel: one x, y, z acceleration sample per transfer.
// ----------------------------------------------------------------------------
interface tai_smp_if #(
  parameter int SAMPLE_BITS = tai_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
  modport mon    (input valid, input ready, input sample_x, input sample_y,
                  input sample_z);
endinterface

// ----- hdl/tai_flt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tai_flt_if
// Output channel: one filtered x, y, z result per transfer.
// ----------------------------------------------------------------------------
interface tai_flt_if #(
  parameter int SAMPLE_BITS = tai_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_x;
  logic signed [SAMPLE_BITS-1:0] filtered_y;
  logic signed [SAMPLE_BITS-1:0] filtered_z;

  modport source (output valid, output filtered_x, output filtered_y,
                  output filtered_z, input ready);
  modport sink   (input valid, input filtered_x, input filtered_y,
                  input filtered_z, output ready);
  modport mon    (input valid, input ready, input filtered_x, input filtered_y,
                  input filtered_z);
endinterface

// ----- hdl/tai_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tai_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tai_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/three_axis_cascaded_iir_highpass_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_cascaded_iir_highpass_core
// Three-axis high-pass filter: a second-order and a first-order direct-form-I
// section in cascade per axis, on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// The block takes one x, y, z sample per transfer and returns one filtered
// x, y, z result per transfer. After the sample transfer each axis in turn
// goes through one history read, five and three products through the single
// multiplier, and one accumulate and one rounding step per section; then the
// results are handed over to the output register. The shared multiplier and
// the per-axis history memory mean that a new sample is taken only after the
// previous one is through. A new sample is accepted once the previous result
// has moved into the output register, even while that result still waits to
// be taken. Coefficients are signed Q2.30 registers on the APB port (byte
// address 4 times the index); the user must write them only while the block
// is idle, which the block itself does not enforce. Results are rounded half
// up and saturated to the sample width; history keeps the saturated values
// and starts at zero.
// ----------------------------------------------------------------------------
module three_axis_cascaded_iir_highpass_core #(
  parameter int SAMPLE_BITS = tai_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = tai_pkg::COEF_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tai_smp_if.sink                           smp_i,
  tai_flt_if.source                         flt_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tai_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [tai_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tai_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  localparam int SB         = SAMPLE_BITS;
  localparam int FRAC_BITS  = COEF_BITS - 2;
  localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
  localparam int ACC        = tai_pkg::ACC_BITS;
  localparam int AXB        = tai_pkg::AXIS_BITS;
  localparam int ENTRY_BITS = tai_pkg::HIST_WORDS * SAMPLE_BITS;
  localparam logic signed [ACC-1:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ACC-1:0] SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC-1:0] SAT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic [AXB-1:0]        LAST_AXIS = AXB'(tai_pkg::AXES - 1);

  // Positions of the history words in one memory entry
  localparam int H_X1 = 0;       // section 1 input, one back
  localparam int H_X2 = SB;      // section 1 input, two back
  localparam int H_YA = 2 * SB;  // section 1 output, one back (section 2 input)
  localparam int H_YB = 3 * SB;  // section 1 output, two back
  localparam int H_Z  = 4 * SB;  // section 2 output, one back

  tai_pkg::state_e   st_q, st_d;
  tai_pkg::reg_idx_e term;

  logic signed [COEF_BITS-1:0] coef_q [tai_pkg::NUM_REGS];
  logic signed [SB-1:0]        smp_q  [tai_pkg::AXES];
  logic signed [SB-1:0]        res_q  [tai_pkg::AXES];
  logic signed [SB-1:0]        out_x_q, out_y_q, out_z_q;
  logic                        ovld_q;
  logic [AXB-1:0]              axis_q;
  logic [2:0]                  tm_q;
  logic signed [ACC-1:0]       acc_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic                        pv_q, psub_q;
  logic signed [SB-1:0]        y1_q;
  logic [tai_pkg::AXES-1:0]    valid_q;
  logic                        rvld_q;

  logic                        smp_acc, flt_free, cfg_wr, last_axis;
  logic                        ram_we, ram_re;
  logic [AXB-1:0]              ram_raddr;
  logic [ENTRY_BITS-1:0]       ram_rdata, ram_wdata, hist;
  logic signed [SB-1:0]        cur, h_x1, h_x2, h_ya, h_yb, h_z;
  logic signed [COEF_BITS-1:0] coef_sel;
  logic signed [SB-1:0]        opnd;
  logic                        sub_sel;
  logic signed [ACC-1:0]       rnd_sum, rnd_shift;
  logic signed [SB-1:0]        rnd_sat;
  logic [tai_pkg::REG_IDX_BITS-1:0] cfg_idx;

  assign smp_acc   = smp_i.valid && smp_i.ready;
  assign flt_free  = !ovld_q || flt_o.ready;
  assign last_axis = (axis_q == LAST_AXIS);
  assign cfg_idx   = paddr[tai_pkg::REG_IDX_BITS+1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;

  // APB register file
  assign pready = 1'b1;
  assign prdata = tai_pkg::APB_DATA_BITS'(coef_q[cfg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tai_pkg::NUM_REGS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      coef_q[cfg_idx] <= pwdata[COEF_BITS-1:0];
    end
  end

  // Sequencer: next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      tai_pkg::ST_IDLE: if (smp_acc) st_d = tai_pkg::ST_READ;
      tai_pkg::ST_READ: st_d = tai_pkg::ST_MAC1;
      tai_pkg::ST_MAC1: if (tm_q == 3'd4) st_d = tai_pkg::ST_FIN1;
      tai_pkg::ST_FIN1: st_d = tai_pkg::ST_RND1;
      tai_pkg::ST_RND1: st_d = tai_pkg::ST_MAC2;
      tai_pkg::ST_MAC2: if (tm_q == 3'd2) st_d = tai_pkg::ST_FIN2;
      tai_pkg::ST_FIN2: st_d = tai_pkg::ST_RND2;
      tai_pkg::ST_RND2: st_d = last_axis ? tai_pkg::ST_DONE : tai_pkg::ST_READ;
      tai_pkg::ST_DONE: if (flt_free) st_d = tai_pkg::ST_IDLE;
      default:          st_d = tai_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    smp_i.ready = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    ram_we      = 1'b0;
    term        = tai_pkg::REG_S1_FEED_0;
    case (st_q)
      tai_pkg::ST_IDLE: begin
        smp_i.ready = 1'b1;
        ram_re      = smp_acc;
      end
      tai_pkg::ST_MAC1: term = tai_pkg::reg_idx_e'(tm_q);
      tai_pkg::ST_MAC2: term = tai_pkg::reg_idx_e'(tm_q + 3'd5);
      tai_pkg::ST_RND2: begin
        ram_we    = 1'b1;
        ram_re    = !last_axis;
        ram_raddr = axis_q + AXB'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tai_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Per-axis history memory
  tai_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (tai_pkg::AXES)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (axis_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as zero history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (ram_we) valid_q[axis_q] <= 1'b1;
      if (ram_re) rvld_q <= valid_q[ram_raddr];
    end
  end

  assign hist = rvld_q ? ram_rdata : '0;
  assign h_x1 = hist[H_X1 +: SB];
  assign h_x2 = hist[H_X2 +: SB];
  assign h_ya = hist[H_YA +: SB];
  assign h_yb = hist[H_YB +: SB];
  assign h_z  = hist[H_Z  +: SB];
  assign cur  = smp_q[axis_q];

  // Shift the history and store the new outputs
  assign ram_wdata = {rnd_sat, h_ya, y1_q, h_x1, cur};

  // Select coefficient and operand of the current term
  always_comb begin
    coef_sel = coef_q[term];
    sub_sel  = 1'b0;
    case (term)
      tai_pkg::REG_S1_FEED_0: opnd = cur;
      tai_pkg::REG_S1_FEED_1: opnd = h_x1;
      tai_pkg::REG_S1_FEED_2: opnd = h_x2;
      tai_pkg::REG_S1_BACK_1: begin
        opnd    = h_ya;
        sub_sel = 1'b1;
      end
      tai_pkg::REG_S1_BACK_2: begin
        opnd    = h_yb;
        sub_sel = 1'b1;
      end
      tai_pkg::REG_S2_FEED_0: opnd = y1_q;
      tai_pkg::REG_S2_FEED_1: opnd = h_ya;
      tai_pkg::REG_S2_BACK_1: begin
        opnd    = h_z;
        sub_sel = 1'b1;
      end
      default: opnd = '0;
    endcase
  end

  // Round half up, shift to integer, saturate
  assign rnd_sum   = acc_q + HALF;
  assign rnd_shift = rnd_sum >>> FRAC_BITS;
  always_comb begin
    if (rnd_shift > SAT_MAX) begin
      rnd_sat = SB'(SAT_MAX);
    end else if (rnd_shift < SAT_MIN) begin
      rnd_sat = SB'(SAT_MIN);
    end else begin
      rnd_sat = rnd_shift[SB-1:0];
    end
  end

  // Term counter, axis counter and product flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_q   <= '0;
      axis_q <= '0;
      pv_q   <= 1'b0;
    end else begin
      pv_q <= (st_q == tai_pkg::ST_MAC1) || (st_q == tai_pkg::ST_MAC2);
      if (st_q == tai_pkg::ST_MAC1 || st_q == tai_pkg::ST_MAC2) begin
        tm_q <= (st_d == st_q) ? tm_q + 3'd1 : 3'd0;
      end else begin
        tm_q <= '0;
      end
      if (smp_acc) begin
        axis_q <= '0;
      end else if (st_q == tai_pkg::ST_RND2 && !last_axis) begin
        axis_q <= axis_q + AXB'(1);
      end
    end
  end

  // Multiply into a product register, then accumulate the registered product
  always_ff @(posedge clk_i) begin
    prod_q <= coef_sel * opnd;
    psub_q <= sub_sel;
    if (st_q == tai_pkg::ST_READ || st_q == tai_pkg::ST_RND1) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= psub_q ? acc_q - ACC'(prod_q) : acc_q + ACC'(prod_q);
    end
    if (st_q == tai_pkg::ST_RND1) y1_q <= rnd_sat;
    if (st_q == tai_pkg::ST_RND2) res_q[axis_q] <= rnd_sat;
    if (smp_acc) begin
      smp_q[0] <= smp_i.sample_x;
      smp_q[1] <= smp_i.sample_y;
      smp_q[2] <= smp_i.sample_z;
    end
  end

  // Output register: load the finished item, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (st_q == tai_pkg::ST_DONE && flt_free) begin
      ovld_q <= 1'b1;
    end else if (flt_o.ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == tai_pkg::ST_DONE && flt_free) begin
      out_x_q <= res_q[0];
      out_y_q <= res_q[1];
      out_z_q <= res_q[2];
    end
  end

  assign flt_o.valid      = ovld_q;
  assign flt_o.filtered_x = out_x_q;
  assign flt_o.filtered_y = out_y_q;
  assign flt_o.filtered_z = out_z_q;

endmodule

// ----- hdl/tai_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tai_chk
// Port-level checks of the three-axis high-pass filter core.
// ----------------------------------------------------------------------------
module tai_chk #(
  parameter int SAMPLE_BITS = tai_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   smp_valid_i,
  input logic                   smp_ready_i,
  input logic                   flt_valid_i,
  input logic                   flt_ready_i,
  input logic [SAMPLE_BITS-1:0] flt_x_i,
  input logic [SAMPLE_BITS-1:0] flt_y_i,
  input logic [SAMPLE_BITS-1:0] flt_z_i
);

  // A sample transfer starts a computation: no second sample next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_valid_i && smp_ready_i) |=> !smp_ready_i)
    else $error("input ready still high after a sample transfer");

  // A result cannot appear straight after its sample was taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_valid_i && smp_ready_i) |=> !$rose(flt_valid_i))
    else $error("result raised right after a sample transfer");

  // A new result is only loaded while the input side was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flt_valid_i) |-> $past(!smp_ready_i))
    else $error("result appeared without a computation in progress");

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flt_valid_i && !flt_ready_i) |=> (flt_valid_i && $stable(flt_x_i)
      && $stable(flt_y_i) && $stable(flt_z_i)))
    else $error("stalled result changed or dropped");

endmodule

bind three_axis_cascaded_iir_highpass_core tai_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tai_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (smp_i.valid),
  .smp_ready_i (smp_i.ready),
  .flt_valid_i (flt_o.valid),
  .flt_ready_i (flt_o.ready),
  .flt_x_i     (flt_o.filtered_x),
  .flt_y_i     (flt_o.filtered_y),
  .flt_z_i     (flt_o.filtered_z)
);
